// File: rtl/core/sls_pkg.sv
// ----------------------------------------------------------------------------
// sls_pkg: shared types and constants for the serpentine LED scanout
// Matrix geometry, request and result layouts, and the internal bundles
// that pass between the sequencer, the pixel memory and the top level.
// ----------------------------------------------------------------------------
package sls_pkg;

	// Matrix geometry
	localparam int ROWS   = 8;
	localparam int COLS   = 8;
	localparam int PIXELS = ROWS * COLS;

	localparam int ROW_CW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int COL_CW = (COLS > 1) ? $clog2(COLS) : 1;
	localparam int ADDR_W = (PIXELS > 1) ? $clog2(PIXELS) : 1;
	localparam int GRB_W  = 24;

	// Request function codes
	typedef enum logic [1:0] {
		FN_SET   = 2'd0,
		FN_CLEAR = 2'd1,
		FN_FRAME = 2'd2,
		FN_SOLID = 2'd3
	} func_t;

	// Sequencer states
	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} seq_state_t;

	// Request payload
	typedef struct packed {
		logic [1:0] func;
		logic [2:0] row;
		logic [2:0] col;
		logic [7:0] green_in;
		logic [7:0] red_in;
		logic [7:0] blue_in;
	} req_t;

	// Result payload
	typedef struct packed {
		logic [7:0] green_out;
		logic [7:0] red_out;
		logic [7:0] blue_out;
		logic       frame_end;
	} result_t;

	// Pixel memory write port
	typedef struct packed {
		logic              en;
		logic              clear;
		logic [ADDR_W-1:0] addr;
		logic [GRB_W-1:0]  data;
	} wr_req_t;

	// Pixel memory read port
	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	// Per-pixel tag issued alongside each read
	typedef struct packed {
		logic valid;
		logic last;
	} tag_t;

endpackage

// File: rtl/core/sls_pixel_mem.sv
// ----------------------------------------------------------------------------
// sls_pixel_mem: frame pixel store
// One write port, one registered read port. Per-entry valid bits give the
// all-zero reset and the clear of every entry at once; an invalid entry reads as zero.
// ----------------------------------------------------------------------------
module sls_pixel_mem
	import sls_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  wr_req_t          wr,
	input  rd_req_t          rd,
	output logic [GRB_W-1:0] rdata
);

	logic [GRB_W-1:0] mem_q [PIXELS];
	logic [PIXELS-1:0] valid_q;
	logic [GRB_W-1:0] rdata_q;

	// Valid bits: cleared by reset or a clear request, set on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.clear) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	// Storage array
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	// Registered read, masked by the valid bit
	always_ff @(posedge clk) begin
		if (rd.en) begin
			rdata_q <= valid_q[rd.addr] ? mem_q[rd.addr] : '0;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/sls_seq.sv
// ----------------------------------------------------------------------------
// sls_seq: serpentine scan sequencer
// Steps a row/column counter once per cycle and forms each pixel address
// with one shared multiply-add unit; even rows run backward, odd forward.
// ----------------------------------------------------------------------------
module sls_seq
	import sls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	output logic    busy,
	output rd_req_t rd,
	output tag_t    tag
);

	seq_state_t state_q, state_d;
	logic [ROW_CW-1:0] row_q;
	logic [COL_CW-1:0] idx_q;
	logic [COL_CW-1:0] col;
	logic row_end;
	logic last;

	assign row_end = (idx_q == COL_CW'(COLS - 1));
	assign last    = row_end && (row_q == ROW_CW'(ROWS - 1));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (go) state_d = S_RUN;
			end
			S_RUN: begin
				if (last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Address unit: serpentine column select and row*COLS + col
	always_comb begin
		col = row_q[0] ? idx_q : (COL_CW'(COLS - 1) - idx_q);
	end

	// Outputs
	always_comb begin
		busy      = 1'b0;
		rd.en     = 1'b0;
		rd.addr   = ADDR_W'(row_q) * ADDR_W'(COLS) + ADDR_W'(col);
		tag.valid = 1'b0;
		tag.last  = 1'b0;
		case (state_q)
			S_RUN: begin
				busy      = 1'b1;
				rd.en     = 1'b1;
				tag.valid = 1'b1;
				tag.last  = last;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

	// State and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			row_q   <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (go) begin
				row_q <= '0;
				idx_q <= '0;
			end else if (state_q == S_RUN) begin
				if (row_end) begin
					idx_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

endmodule

// File: rtl/core/serpentine_led_frame_scanout.sv
// ----------------------------------------------------------------------------
// serpentine_led_frame_scanout: LED matrix frame buffer with serpentine scan
// Set-pixel and clear requests take effect at the accepting edge, busy stays
// low. Frame and solid-colour requests hold busy while the scan counter
// steps through the 64 pixels, one per cycle, through the single memory read
// port; results pass the read and output registers and strobe one per cycle.
// Reset clears all pixels through per-entry valid bits; no clearing pass.
// ----------------------------------------------------------------------------
module serpentine_led_frame_scanout
	import sls_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  req_t    req,
	output logic    strobe,
	output result_t result
);

	logic accept;
	logic go;
	logic in_range;
	wr_req_t wr;
	rd_req_t rd;
	tag_t tag;
	logic [GRB_W-1:0] rdata;

	logic solid_q;
	logic [GRB_W-1:0] color_q;
	logic valid_s1, last_s1;
	logic strobe_q;
	result_t result_q;
	logic [GRB_W-1:0] pix;

	// Request decode
	assign accept   = start && !busy;
	assign in_range = ({1'b0, req.row} < 4'(ROWS)) && ({1'b0, req.col} < 4'(COLS));
	assign go       = accept && ((req.func == FN_FRAME) || (req.func == FN_SOLID));

	always_comb begin
		wr.en    = accept && (req.func == FN_SET) && in_range;
		wr.clear = accept && (req.func == FN_CLEAR);
		wr.addr  = ADDR_W'(32'(req.row) * COLS + 32'(req.col));
		wr.data  = {req.green_in, req.red_in, req.blue_in};
	end

	sls_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.busy   (busy),
		.rd     (rd),
		.tag    (tag)
	);

	sls_pixel_mem u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rdata  (rdata)
	);

	// Emit mode and solid colour, captured per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			solid_q <= 1'b0;
		end else if (go) begin
			solid_q <= (req.func == FN_SOLID);
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			color_q <= {req.green_in, req.red_in, req.blue_in};
		end
	end

	// Read stage tag, aligned with the memory read register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1  <= 1'b0;
		end else begin
			valid_s1 <= tag.valid;
			last_s1  <= tag.last;
		end
	end

	// Output register
	assign pix = solid_q ? color_q : rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_q.green_out <= pix[23:16];
			result_q.red_out   <= pix[15:8];
			result_q.blue_out  <= pix[7:0];
			result_q.frame_end <= last_s1;
		end
	end

	assign strobe = strobe_q;
	assign result = result_q;

	// Checks
	a_busy_fall_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(tag.last))
		else $error("busy dropped without a final pixel read");

	a_last_reaches_output: assert property (@(posedge clk) disable iff (!arst_n)
		tag.last |-> ##2 (strobe && result.frame_end))
		else $error("final pixel did not strobe out with frame_end");

	a_read_to_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> strobe)
		else $error("read stage did not produce a result");

endmodule

// File: tb/sv/serpentine_led_frame_scanout_tb.sv
// ----------------------------------------------------------------------------
// serpentine_led_frame_scanout_tb: self-checking bench for the LED scanout
// Drives set, clear, frame and solid-colour requests through the start/busy
// handshake and keeps a local copy of the pixel store. Each accepted emit
// request queues its 64 expected pixels in serpentine order, and every strobed
// result is compared against the oldest queued pixel.
// ----------------------------------------------------------------------------
module serpentine_led_frame_scanout_tb
	import sls_pkg::*;
();

	localparam int RUN_LIMIT = 4000000;
	localparam int TAIL_CYCLES = 10;

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	req_t    req;
	logic    strobe;
	result_t result;

	// Local copy of the frame and the pixels still owed by the block
	logic [GRB_W-1:0] frame_copy [PIXELS];
	result_t          owed_pixels [$];

	int sender_idle_pct;
	bit failed;

	serpentine_led_frame_scanout dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.strobe (strobe),
		.result (result)
	);

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Hard stop in case the block hangs
	initial begin
		#(RUN_LIMIT);
		$display("serpentine_led_frame_scanout test failed");
		$finish;
	end

	function automatic req_t make_req(func_t f, logic [2:0] row, logic [2:0] col,
			logic [23:0] grb);
		req_t r;
		r.func     = f;
		r.row      = row;
		r.col      = col;
		r.green_in = grb[23:16];
		r.red_in   = grb[15:8];
		r.blue_in  = grb[7:0];
		return r;
	endfunction

	function automatic result_t pixel_result(logic [23:0] grb, logic last);
		result_t p;
		p.green_out = grb[23:16];
		p.red_out   = grb[15:8];
		p.blue_out  = grb[7:0];
		p.frame_end = last;
		return p;
	endfunction

	// Colour byte with a bias toward 00, FF and 80
	function automatic logic [7:0] rand_byte();
		int pick;
		pick = $urandom_range(9);
		if (pick == 0) begin
			return 8'h00;
		end else if (pick == 1) begin
			return 8'hFF;
		end else if (pick == 2) begin
			return 8'h80;
		end
		return 8'($urandom);
	endfunction

	function automatic logic [23:0] rand_grb();
		return {rand_byte(), rand_byte(), rand_byte()};
	endfunction

	// Update the frame copy and queue the pixels a request produces
	task automatic apply_request(req_t r);
		int k;
		int c;
		logic [23:0] grb;
		grb = {r.green_in, r.red_in, r.blue_in};
		k = 0;
		case (func_t'(r.func))
			FN_SET: begin
				if (r.row < ROWS && r.col < COLS)
					frame_copy[r.row * COLS + r.col] = grb;
			end
			FN_CLEAR: begin
				for (int i = 0; i < PIXELS; i++)
					frame_copy[i] = '0;
			end
			FN_FRAME: begin
				// even rows walk from the last column down, odd rows walk up
				for (int rw = 0; rw < ROWS; rw++) begin
					for (int i = 0; i < COLS; i++) begin
						c = rw[0] ? i : COLS - 1 - i;
						owed_pixels.push_back(pixel_result(frame_copy[rw * COLS + c],
							k == PIXELS - 1));
						k++;
					end
				end
			end
			default: begin
				for (int i = 0; i < PIXELS; i++)
					owed_pixels.push_back(pixel_result(grb, i == PIXELS - 1));
			end
		endcase
	endtask

	// Issue one request; returns at the edge that accepts it
	task automatic send_request(req_t r);
		while ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			req   <= req_t'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (busy);
		apply_request(r);
	endtask

	// Result check against the oldest owed pixel
	always @(posedge clk) begin
		result_t exp_px;
		if (arst_n && strobe) begin
			if (owed_pixels.size() == 0) begin
				failed = 1'b1;
				$display("%0t: unexpected pixel, none owed; actual g=%h r=%h b=%h end=%b",
					$time, result.green_out, result.red_out, result.blue_out,
					result.frame_end);
			end else begin
				exp_px = owed_pixels.pop_front();
				if (result.green_out !== exp_px.green_out ||
						result.red_out !== exp_px.red_out ||
						result.blue_out !== exp_px.blue_out ||
						result.frame_end !== exp_px.frame_end) begin
					failed = 1'b1;
					$display({"%0t: pixel mismatch expected g=%h r=%h b=%h end=%b",
						" actual g=%h r=%h b=%h end=%b"},
						$time, exp_px.green_out, exp_px.red_out, exp_px.blue_out,
						exp_px.frame_end, result.green_out, result.red_out,
						result.blue_out, result.frame_end);
				end
			end
		end
	end

	// Frame straight out of reset, plus unused fields set on the emit
	task automatic test_blank_frame();
		send_request(make_req(FN_FRAME, 3'd7, 3'd7, 24'hFFFFFF));
		send_request(make_req(FN_SOLID, 3'd5, 3'd2, 24'h000000));
	endtask

	// Corners and inner pixels with extreme colours
	task automatic test_corner_pixels();
		send_request(make_req(FN_SET, 3'd0, 3'd0, 24'hFFFFFF));
		send_request(make_req(FN_SET, 3'd0, 3'd7, 24'h800000));
		send_request(make_req(FN_SET, 3'd7, 3'd0, 24'h00FF00));
		send_request(make_req(FN_SET, 3'd7, 3'd7, 24'h0000FF));
		send_request(make_req(FN_SET, 3'd3, 3'd4, 24'hA55AC3));
		send_request(make_req(FN_SET, 3'd4, 3'd3, 24'h5AA53C));
		send_request(make_req(FN_SET, 3'd1, 3'd6, 24'h010101));
		send_request(make_req(FN_FRAME, 3'd0, 3'd0, 24'h000000));
	endtask

	// Solid colours must leave the frame untouched
	task automatic test_solid_colors();
		send_request(make_req(FN_SOLID, 3'd0, 3'd0, 24'hFFFFFF));
		send_request(make_req(FN_SOLID, 3'd7, 3'd7, 24'h800001));
		send_request(make_req(FN_FRAME, 3'd2, 3'd5, 24'h123456));
	endtask

	// Clear with junk in the unused fields, then read back
	task automatic test_clear_all();
		send_request(make_req(FN_CLEAR, 3'd7, 3'd7, 24'hFFFFFF));
		send_request(make_req(FN_FRAME, 3'd6, 3'd1, 24'hFFFFFF));
		send_request(make_req(FN_SET, 3'd2, 3'd3, 24'hFF00FF));
		send_request(make_req(FN_FRAME, 3'd0, 3'd0, 24'h000000));
	endtask

	// Mostly pixel writes with frame and solid emits between them
	task automatic test_random_traffic(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send_request(make_req(FN_SET, 3'($urandom), 3'($urandom), rand_grb()));
			end else if (pick < 60) begin
				send_request(make_req(FN_CLEAR, 3'($urandom), 3'($urandom), 24'($urandom)));
			end else if (pick < 85) begin
				send_request(make_req(FN_FRAME, 3'($urandom), 3'($urandom), 24'($urandom)));
			end else begin
				send_request(make_req(FN_SOLID, 3'($urandom), 3'($urandom), rand_grb()));
			end
		end
	endtask

	// Test sequence
	initial begin
		failed = 1'b0;
		sender_idle_pct = 0;
		for (int i = 0; i < PIXELS; i++)
			frame_copy[i] = '0;
		arst_n = 1'b0;
		start  = 1'b0;
		req    = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		sender_idle_pct = 30;
		test_blank_frame();
		test_corner_pixels();
		test_solid_colors();
		test_clear_all();

		test_random_traffic(170);
		sender_idle_pct = 64;
		test_random_traffic(160);
		sender_idle_pct = 0;
		test_random_traffic(170);

		start <= 1'b0;
		while (owed_pixels.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (!failed && owed_pixels.size() == 0) begin
			$display("serpentine_led_frame_scanout test passed");
		end else begin
			$display("serpentine_led_frame_scanout test failed");
		end
		$finish;
	end

endmodule
